// File: sv/wash_cycle_sequencer_unit_macros.svh
// ============================================================================
// Assertion macros for the wash cycle sequencer
// Shared property shapes used by the port-level checker.
// ============================================================================
`ifndef WASH_CYCLE_SEQUENCER_UNIT_MACROS_SVH
`define WASH_CYCLE_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WCS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wcs checker: implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define WCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wcs checker: next-cycle implication failed");

`endif

// File: sv/wcs_pkg.sv
// ============================================================================
// wcs_pkg
// Types, codes, masks and lookup tables of the wash cycle sequencer.
// ============================================================================
package wcs_pkg;

    localparam logic       REQ_TICK   = 1'b0;
    localparam logic       REQ_BUTTON = 1'b1;
    localparam logic [1:0] BTN_RUN    = 2'd0;

    localparam logic [1:0] CFG_BLANK_TICK   = 2'd0;
    localparam logic [1:0] CFG_REFRESH_TICK = 2'd1;
    localparam logic [1:0] CFG_SECOND_MATCH = 2'd2;

    localparam logic [7:0] BLANK_TICK_RST   = 8'd9;
    localparam logic [7:0] REFRESH_TICK_RST = 8'd10;
    localparam logic [7:0] SECOND_MATCH_RST = 8'd255;

    localparam logic [2:0] STAGE_IDLE  = 3'd0;
    localparam logic [2:0] STAGE_FIRST = 3'd1;
    localparam logic [2:0] STAGE_LAST  = 3'd4;
    localparam logic [2:0] STAGE_DONE  = 3'd5;

    localparam logic [7:0] IND_STAGE_KEEP = 8'h87;
    localparam logic [7:0] IND_LEVEL_CLR  = 8'hF8;
    localparam logic [7:0] IND_RUN_CLR    = 8'h7F;
    localparam logic [7:0] IND_WAIT_KEEP  = 8'h07;

    localparam logic [3:0] BCD_MAX = 4'd9;

    typedef struct packed {
        logic [6:0] seg_pattern;
        logic       seg_write;
        logic [1:0] digit_off_n;
        logic [7:0] led_byte;
        logic       led_send;
        logic       washing;
        logic [2:0] stage_now;
        logic [3:0] tens_digit;
        logic [3:0] ones_digit;
    } wcs_result_t;

    // Segment pattern, bit6 = a .. bit0 = g.
    function automatic logic [6:0] seg_code(input logic [3:0] digit);
        logic [6:0] pat;
        case (digit)
            4'd0:    pat = 7'h7E;
            4'd1:    pat = 7'h30;
            4'd2:    pat = 7'h6D;
            4'd3:    pat = 7'h79;
            4'd4:    pat = 7'h33;
            4'd5:    pat = 7'h5B;
            4'd6:    pat = 7'h5F;
            4'd7:    pat = 7'h70;
            4'd8:    pat = 7'h7F;
            4'd9:    pat = 7'h73;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

    // Stage duration in BCD {tens, ones}, per load level and stage.
    function automatic logic [7:0] stage_bcd(input logic [1:0] level, input logic [2:0] stage);
        logic [7:0] bcd;
        case ({level, stage})
            {2'd1, 3'd1}: bcd = 8'h01;
            {2'd1, 3'd2}: bcd = 8'h03;
            {2'd1, 3'd3}: bcd = 8'h02;
            {2'd1, 3'd4}: bcd = 8'h03;
            {2'd2, 3'd1}: bcd = 8'h02;
            {2'd2, 3'd2}: bcd = 8'h07;
            {2'd2, 3'd3}: bcd = 8'h04;
            {2'd2, 3'd4}: bcd = 8'h06;
            {2'd3, 3'd1}: bcd = 8'h03;
            {2'd3, 3'd2}: bcd = 8'h10;
            {2'd3, 3'd3}: bcd = 8'h05;
            {2'd3, 3'd4}: bcd = 8'h09;
            default:      bcd = 8'h00;
        endcase
        return bcd;
    endfunction

    // Indicator bits 0-2 for a level button.
    function automatic logic [2:0] level_onehot(input logic [1:0] level);
        logic [2:0] oh;
        case (level)
            2'd1:    oh = 3'b001;
            2'd2:    oh = 3'b010;
            2'd3:    oh = 3'b100;
            default: oh = 3'b000;
        endcase
        return oh;
    endfunction

    // Indicator bits 3-6 for a running stage.
    function automatic logic [3:0] stage_onehot(input logic [2:0] stage);
        logic [3:0] oh;
        case (stage)
            3'd1:    oh = 4'b0001;
            3'd2:    oh = 4'b0010;
            3'd3:    oh = 4'b0100;
            3'd4:    oh = 4'b1000;
            default: oh = 4'b0000;
        endcase
        return oh;
    endfunction

endpackage

// File: sv/wash_cycle_sequencer_unit.sv
// ============================================================================
// wash_cycle_sequencer_unit
// Four-stage wash sequencer with BCD countdown and multiplexed display drive.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready) carries one event per transaction: a timer
//   tick (s_req_type = 0) or a button (s_req_type = 1, s_button_code 0 toggles
//   run, 1..3 picks the load level while waiting).
//   Result channel (m_valid/m_ready) returns exactly one result per event:
//   segment and digit-enable latches, indicator byte and send strobe, and the
//   stage and remaining seconds after the event.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 blank_tick, 1 refresh_tick, 2 second_match); other indexes are dropped.
//   The result of an event accepted at one edge is on the m_ ports after that
//   edge. Throughput is one event per cycle while the receiver takes results;
//   the state update is a single combinational pass into the result register.
//   When the receiver stalls, the result register holds and s_ready stays
//   high only in the cycle that m_ready drains it.
//   Synchronous reset (aresetn low) clears all sequencer state and the result
//   valid flag, and restores the registers to 9, 10 and 255.
// ============================================================================
module wash_cycle_sequencer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [1:0] s_button_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_seg_pattern,
    output logic       m_seg_write,
    output logic [1:0] m_digit_off_n,
    output logic [7:0] m_led_byte,
    output logic       m_led_send,
    output logic       m_washing,
    output logic [2:0] m_stage_now,
    output logic [3:0] m_tens_digit,
    output logic [3:0] m_ones_digit
);

    wcs_pkg::wcs_result_t core_result;
    wcs_pkg::wcs_result_t out_data;
    logic                 accept;

    assign accept = s_valid && s_ready;

    wcs_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .req_type    (s_req_type),
        .button_code (s_button_code),
        .result      (core_result)
    );

    wcs_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .load_data (core_result),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .can_load  (s_ready),
        .m_data    (out_data)
    );

    assign m_seg_pattern = out_data.seg_pattern;
    assign m_seg_write   = out_data.seg_write;
    assign m_digit_off_n = out_data.digit_off_n;
    assign m_led_byte    = out_data.led_byte;
    assign m_led_send    = out_data.led_send;
    assign m_washing     = out_data.washing;
    assign m_stage_now   = out_data.stage_now;
    assign m_tens_digit  = out_data.tens_digit;
    assign m_ones_digit  = out_data.ones_digit;

endmodule

// File: sv/wcs_core.sv
// ============================================================================
// wcs_core
// Sequencer state, timing registers and the single-pass update per transaction.
// ============================================================================
module wcs_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_wdata,
    input  logic                 accept,
    input  logic                 req_type,
    input  logic [1:0]           button_code,
    output wcs_pkg::wcs_result_t result
);

    logic [7:0] blank_tick_reg, refresh_tick_reg, second_match_reg;
    logic [7:0] tick_count_reg, tick_count_next;
    logic [7:0] refresh_count_reg, refresh_count_next;
    logic       run_on_reg, run_on_next;
    logic       time_up_reg, time_up_next;
    logic       digit_phase_reg, digit_phase_next;
    logic [3:0] tens_reg, tens_next;
    logic [3:0] ones_reg, ones_next;
    logic [1:0] load_level_reg, load_level_next;
    logic [2:0] stage_reg, stage_next;
    logic       active_reg, active_next;
    logic [7:0] indicator_reg, indicator_next;
    logic [6:0] seg_latch_reg, seg_latch_next;
    logic [1:0] digit_latch_reg, digit_latch_next;

    logic [7:0] tc_inc;
    logic [7:0] rc_inc;
    logic       wrote;
    logic       sent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blank_tick_reg   <= wcs_pkg::BLANK_TICK_RST;
            refresh_tick_reg <= wcs_pkg::REFRESH_TICK_RST;
            second_match_reg <= wcs_pkg::SECOND_MATCH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wcs_pkg::CFG_BLANK_TICK:   blank_tick_reg   <= cfg_wdata;
                wcs_pkg::CFG_REFRESH_TICK: refresh_tick_reg <= cfg_wdata;
                wcs_pkg::CFG_SECOND_MATCH: second_match_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        tick_count_next    = tick_count_reg;
        refresh_count_next = refresh_count_reg;
        run_on_next        = run_on_reg;
        time_up_next       = time_up_reg;
        digit_phase_next   = digit_phase_reg;
        tens_next          = tens_reg;
        ones_next          = ones_reg;
        load_level_next    = load_level_reg;
        stage_next         = stage_reg;
        active_next        = active_reg;
        indicator_next     = indicator_reg;
        seg_latch_next     = seg_latch_reg;
        digit_latch_next   = digit_latch_reg;
        wrote              = 1'b0;
        sent               = 1'b0;
        tc_inc             = tick_count_reg + 8'd1;
        rc_inc             = refresh_count_reg + 8'd1;

        // Event handling
        if (req_type == wcs_pkg::REQ_TICK) begin
            tick_count_next = tc_inc;
            if (tc_inc == blank_tick_reg) begin
                seg_latch_next   = 7'd0;
                digit_latch_next = 2'b11;
                wrote            = 1'b1;
            end else if (tc_inc == refresh_tick_reg) begin
                refresh_count_next = rc_inc;
                // one second passed: count down while running
                if (rc_inc == second_match_reg && run_on_reg) begin
                    if (ones_reg == 4'd0) begin
                        if (tens_reg == 4'd0) begin
                            time_up_next = 1'b1;
                        end else begin
                            tens_next = tens_reg - 4'd1;
                            ones_next = wcs_pkg::BCD_MAX;
                        end
                    end else begin
                        ones_next = ones_reg - 4'd1;
                    end
                end
                if (!digit_phase_reg) begin
                    digit_latch_next = digit_latch_reg & 2'b10;
                    if (tens_next <= wcs_pkg::BCD_MAX) begin
                        seg_latch_next = wcs_pkg::seg_code(tens_next);
                    end
                end else begin
                    digit_latch_next = digit_latch_reg & 2'b01;
                    if (ones_next <= wcs_pkg::BCD_MAX) begin
                        seg_latch_next = wcs_pkg::seg_code(ones_next);
                    end
                end
                wrote            = 1'b1;
                sent             = 1'b1;
                tick_count_next  = 8'd1;
                digit_phase_next = !digit_phase_reg;
            end
        end else if (button_code != wcs_pkg::BTN_RUN) begin
            if (!active_reg) begin
                load_level_next = button_code;
                indicator_next  = (indicator_reg & wcs_pkg::IND_LEVEL_CLR)
                                | {5'd0, wcs_pkg::level_onehot(button_code)};
            end
        end else begin
            run_on_next    = !run_on_reg;
            indicator_next = (indicator_reg & wcs_pkg::IND_RUN_CLR) | {!run_on_reg, 7'd0};
        end

        // Settle: start the cycle, advance the stage, drop back to wait at the end
        if (!active_reg && run_on_next && load_level_next != 2'd0) begin
            active_next = 1'b1;
        end
        if (active_next) begin
            if (stage_next == wcs_pkg::STAGE_DONE) begin
                run_on_next    = 1'b0;
                stage_next     = wcs_pkg::STAGE_IDLE;
                tens_next      = 4'd0;
                ones_next      = 4'd0;
                indicator_next = indicator_next & wcs_pkg::IND_WAIT_KEEP;
                active_next    = 1'b0;
            end else if (time_up_next) begin
                stage_next         = stage_reg + 3'd1;
                refresh_count_next = 8'd0;
                if (load_level_next != 2'd0) begin
                    if (stage_next >= wcs_pkg::STAGE_FIRST && stage_next <= wcs_pkg::STAGE_LAST)
                    begin
                        {tens_next, ones_next} = wcs_pkg::stage_bcd(load_level_next, stage_next);
                        indicator_next = (indicator_next & wcs_pkg::IND_STAGE_KEEP)
                                       | {1'b0, wcs_pkg::stage_onehot(stage_next), 3'd0};
                    end else begin
                        indicator_next = indicator_next & wcs_pkg::IND_STAGE_KEEP;
                    end
                end
                time_up_next = 1'b0;
                if (stage_next == wcs_pkg::STAGE_DONE) begin
                    run_on_next    = 1'b0;
                    stage_next     = wcs_pkg::STAGE_IDLE;
                    tens_next      = 4'd0;
                    ones_next      = 4'd0;
                    indicator_next = indicator_next & wcs_pkg::IND_WAIT_KEEP;
                    active_next    = 1'b0;
                end
            end
        end
    end

    always_comb begin
        result.seg_pattern = seg_latch_next;
        result.seg_write   = wrote;
        result.digit_off_n = digit_latch_next;
        result.led_byte    = sent ? indicator_reg : indicator_next;
        result.led_send    = sent;
        result.washing     = active_next;
        result.stage_now   = stage_next;
        result.tens_digit  = tens_next;
        result.ones_digit  = ones_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg    <= 8'd0;
            refresh_count_reg <= 8'd0;
            run_on_reg        <= 1'b0;
            time_up_reg       <= 1'b0;
            digit_phase_reg   <= 1'b0;
            tens_reg          <= 4'd0;
            ones_reg          <= 4'd0;
            load_level_reg    <= 2'd0;
            stage_reg         <= wcs_pkg::STAGE_IDLE;
            active_reg        <= 1'b0;
            indicator_reg     <= 8'd0;
            seg_latch_reg     <= 7'd0;
            digit_latch_reg   <= 2'd0;
        end else if (accept) begin
            tick_count_reg    <= tick_count_next;
            refresh_count_reg <= refresh_count_next;
            run_on_reg        <= run_on_next;
            time_up_reg       <= time_up_next;
            digit_phase_reg   <= digit_phase_next;
            tens_reg          <= tens_next;
            ones_reg          <= ones_next;
            load_level_reg    <= load_level_next;
            stage_reg         <= stage_next;
            active_reg        <= active_next;
            indicator_reg     <= indicator_next;
            seg_latch_reg     <= seg_latch_next;
            digit_latch_reg   <= digit_latch_next;
        end
    end

endmodule

// File: sv/wcs_out_reg.sv
// ============================================================================
// wcs_out_reg
// Result register with valid flag; loads a new result while the old one drains.
// ============================================================================
module wcs_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  wcs_pkg::wcs_result_t load_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 can_load,
    output wcs_pkg::wcs_result_t m_data
);

    logic                 valid_reg, valid_next;
    wcs_pkg::wcs_result_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // hold the payload until a new transaction replaces it
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

// File: sv/wcs_checker.sv
// ============================================================================
// wcs_checker
// Port-level checks of the wash cycle sequencer, bound to the top level.
// ============================================================================
`include "wash_cycle_sequencer_unit_macros.svh"

module wcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_seg_pattern,
    input logic       m_seg_write,
    input logic [7:0] m_led_byte,
    input logic       m_led_send,
    input logic       m_washing,
    input logic [2:0] m_stage_now,
    input logic [3:0] m_tens_digit,
    input logic [3:0] m_ones_digit
);

    // a stalled result keeps its payload
    `WCS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_led_byte) && $stable(m_seg_pattern))

    // an empty result register never blocks the input side
    `WCS_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // every accepted transaction shows a result next cycle
    `WCS_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)

    // a send always comes with a segment write
    `WCS_ASSERT_IMPL(a_send_writes_seg, aclk, aresetn, m_valid && m_led_send, m_seg_write)

    // while waiting, stage and countdown sit at zero
    `WCS_ASSERT_IMPL(a_wait_cleared, aclk, aresetn, m_valid && !m_washing, m_stage_now == 3'd0 && m_tens_digit == 4'd0 && m_ones_digit == 4'd0)

endmodule

bind wash_cycle_sequencer_unit wcs_checker u_wcs_checker (.*);

// File: dv/wcs_scoreboard.sv
// ============================================================================
// wcs_scoreboard
// Watches the event and result channels of the wash cycle sequencer, keeps
// its own model of the sequencer and register file, and compares every
// result transaction field by field with the oldest predicted result.
// ============================================================================
module wcs_scoreboard
    import wcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_req_type,
    input  logic [1:0] s_button_code,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [6:0] m_seg_pattern,
    input  logic       m_seg_write,
    input  logic [1:0] m_digit_off_n,
    input  logic [7:0] m_led_byte,
    input  logic       m_led_send,
    input  logic       m_washing,
    input  logic [2:0] m_stage_now,
    input  logic [3:0] m_tens_digit,
    input  logic [3:0] m_ones_digit,
    output int         fail_count,
    output int         pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [6:0] SEG_LUT [0:9] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h73
    };
    localparam int STAGE_SECS [0:2][0:3] = '{
        '{1, 3, 2, 3}, '{2, 7, 4, 6}, '{3, 10, 5, 9}
    };

    // register file copy
    logic [7:0] cfg_blank, cfg_refresh, cfg_match;

    // sequencer model
    logic [7:0] ticks, refreshes, ind_byte;
    logic       run_flag, secs_expired, show_ones, cycle_active;
    logic [3:0] cnt_tens, cnt_ones;
    logic [1:0] level;
    logic [2:0] cur_stage;
    logic [6:0] seg_hold;
    logic [1:0] dig_hold;

    wcs_result_t result_q [$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
    end

    task automatic finish_wash();
        run_flag     = 1'b0;
        cur_stage    = STAGE_IDLE;
        cnt_tens     = 4'd0;
        cnt_ones     = 4'd0;
        ind_byte     = ind_byte & IND_WAIT_KEEP;
        cycle_active = 1'b0;
    endtask

    task automatic wash_step(input logic req, input logic [1:0] code,
                             output wcs_result_t res);
        logic       wrote, sent;
        logic [7:0] sent_byte, keep;
        int         secs;
        wrote     = 1'b0;
        sent      = 1'b0;
        sent_byte = 8'd0;

        if (req == REQ_TICK) begin
            ticks = ticks + 8'd1;
            if (ticks == cfg_blank) begin
                seg_hold = 7'd0;
                dig_hold = 2'b11;
                wrote    = 1'b1;
            end else if (ticks == cfg_refresh) begin
                refreshes = refreshes + 8'd1;
                // one countdown second, only while running
                if (refreshes == cfg_match && run_flag) begin
                    if (cnt_ones == 4'd0) begin
                        if (cnt_tens == 4'd0) begin
                            secs_expired = 1'b1;
                        end else begin
                            cnt_tens = cnt_tens - 4'd1;
                            cnt_ones = BCD_MAX;
                        end
                    end else begin
                        cnt_ones = cnt_ones - 4'd1;
                    end
                end
                if (!show_ones) begin
                    dig_hold = dig_hold & 2'b10;
                    if (cnt_tens <= BCD_MAX) seg_hold = SEG_LUT[cnt_tens];
                end else begin
                    dig_hold = dig_hold & 2'b01;
                    if (cnt_ones <= BCD_MAX) seg_hold = SEG_LUT[cnt_ones];
                end
                wrote     = 1'b1;
                sent      = 1'b1;
                sent_byte = ind_byte;
                ticks     = 8'd1;
                show_ones = !show_ones;
            end
        end else if (code != BTN_RUN) begin
            if (!cycle_active) begin
                level    = code;
                ind_byte = (ind_byte & IND_LEVEL_CLR) | (8'd1 << (code - 2'd1));
            end
        end else begin
            run_flag    = !run_flag;
            ind_byte[7] = run_flag;
        end

        // settle: start, advance, wrap up at the last stage
        if (!cycle_active && run_flag && level != 2'd0) cycle_active = 1'b1;
        if (cycle_active) begin
            if (cur_stage == STAGE_DONE) begin
                finish_wash();
            end else if (secs_expired) begin
                cur_stage = cur_stage + 3'd1;
                refreshes = 8'd0;
                if (level != 2'd0) begin
                    keep = ind_byte & IND_STAGE_KEEP;
                    if (cur_stage >= STAGE_FIRST && cur_stage <= STAGE_LAST) begin
                        secs     = STAGE_SECS[level - 2'd1][cur_stage - 3'd1];
                        cnt_tens = 4'(secs / 10);
                        cnt_ones = 4'(secs % 10);
                        ind_byte = keep | (8'd1 << (cur_stage + 3'd2));
                    end else begin
                        ind_byte = keep;
                    end
                end
                secs_expired = 1'b0;
                if (cur_stage == STAGE_DONE) finish_wash();
            end
        end

        res.seg_pattern = seg_hold;
        res.seg_write   = wrote;
        res.digit_off_n = dig_hold;
        res.led_byte    = sent ? sent_byte : ind_byte;
        res.led_send    = sent;
        res.washing     = cycle_active;
        res.stage_now   = cur_stage;
        res.tens_digit  = cnt_tens;
        res.ones_digit  = cnt_ones;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        wcs_result_t want;
        if (!aresetn) begin
            cfg_blank    = BLANK_TICK_RST;
            cfg_refresh  = REFRESH_TICK_RST;
            cfg_match    = SECOND_MATCH_RST;
            ticks        = 8'd0;
            refreshes    = 8'd0;
            ind_byte     = 8'd0;
            run_flag     = 1'b0;
            secs_expired = 1'b0;
            show_ones    = 1'b0;
            cycle_active = 1'b0;
            cnt_tens     = 4'd0;
            cnt_ones     = 4'd0;
            level        = 2'd0;
            cur_stage    = STAGE_IDLE;
            seg_hold     = 7'd0;
            dig_hold     = 2'd0;
            result_q.delete();
        end else begin
            // compare before predicting: a result is registered and leaves only after its event
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("seg_pattern", want.seg_pattern, m_seg_pattern);
                    check_field("seg_write",   want.seg_write,   m_seg_write);
                    check_field("digit_off_n", want.digit_off_n, m_digit_off_n);
                    check_field("led_byte",    want.led_byte,    m_led_byte);
                    check_field("led_send",    want.led_send,    m_led_send);
                    check_field("washing",     want.washing,     m_washing);
                    check_field("stage_now",   want.stage_now,   m_stage_now);
                    check_field("tens_digit",  want.tens_digit,  m_tens_digit);
                    check_field("ones_digit",  want.ones_digit,  m_ones_digit);
                end
            end
            if (s_valid && s_ready) begin
                wash_step(s_req_type, s_button_code, want);
                result_q.push_back(want);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BLANK_TICK:   cfg_blank   = cfg_wdata;
                    CFG_REFRESH_TICK: cfg_refresh = cfg_wdata;
                    CFG_SECOND_MATCH: cfg_match   = cfg_wdata;
                    default: ;
                endcase
            end
        end
        pending_results = result_q.size();
    end

endmodule

// File: dv/tb_top.sv
// ============================================================================
// tb_top
// Stimulus for the wash cycle sequencer: directed events, full wash cycles
// at every load level with a pause, then random events over several display
// settings, with random idling, a long result stall and a drain pause.
// ============================================================================
module tb_top;
    import wcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam logic [1:0] BTN_LEVEL1  = 2'd1;
    localparam logic [1:0] BTN_LEVEL2  = 2'd2;
    localparam logic [1:0] BTN_LEVEL3  = 2'd3;
    localparam int         HOLD_CYCLES = 200;
    localparam int         PHASE_ITEMS = 120;
    localparam int         CALM_ITEMS  = 150;
    localparam int         LIMIT       = 500000;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid, s_ready, s_req_type;
    logic [1:0] s_button_code;
    logic       m_valid, m_ready;
    logic [6:0] m_seg_pattern;
    logic       m_seg_write;
    logic [1:0] m_digit_off_n;
    logic [7:0] m_led_byte;
    logic       m_led_send, m_washing;
    logic [2:0] m_stage_now;
    logic [3:0] m_tens_digit, m_ones_digit;

    int   fail_count;
    int   pending_results;
    int   cycle_count;
    logic calm;
    logic hold_req;

    wash_cycle_sequencer_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_button_code(s_button_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_seg_pattern(m_seg_pattern),
        .m_seg_write  (m_seg_write),
        .m_digit_off_n(m_digit_off_n),
        .m_led_byte   (m_led_byte),
        .m_led_send   (m_led_send),
        .m_washing    (m_washing),
        .m_stage_now  (m_stage_now),
        .m_tens_digit (m_tens_digit),
        .m_ones_digit (m_ones_digit)
    );

    wcs_scoreboard u_scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_button_code  (s_button_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_seg_pattern  (m_seg_pattern),
        .m_seg_write    (m_seg_write),
        .m_digit_off_n  (m_digit_off_n),
        .m_led_byte     (m_led_byte),
        .m_led_send     (m_led_send),
        .m_washing      (m_washing),
        .m_stage_now    (m_stage_now),
        .m_tens_digit   (m_tens_digit),
        .m_ones_digit   (m_ones_digit),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    // Offer one event transaction and hold it until accepted.
    task automatic send_event(input logic req, input logic [1:0] code);
        while (!calm && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_button_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_event(REQ_TICK, 2'($urandom_range(3)));
    endtask

    // Stop offering and wait for every predicted result to come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
    endtask

    // One countdown second: match the next refresh, then send one refreshing tick.
    task automatic tick_second();
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SECOND_MATCH;
        cfg_wdata <= u_scoreboard.refreshes + 8'd1;
        @(negedge aclk);
        cfg_we <= 1'b0;
        send_ticks(1);
    endtask

    task automatic program_regs(input logic [7:0] blank, input logic [7:0] refresh,
                                input logic [7:0] match);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BLANK_TICK;
        cfg_wdata <= blank;
        @(negedge aclk);
        cfg_index <= CFG_REFRESH_TICK;
        cfg_wdata <= refresh;
        @(negedge aclk);
        cfg_index <= CFG_SECOND_MATCH;
        cfg_wdata <= match;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_events(input int count, input int button_pct);
        repeat (count) begin
            if ($urandom_range(99) < button_pct)
                send_event(REQ_BUTTON, 2'($urandom_range(3)));
            else
                send_event(REQ_TICK, 2'($urandom_range(3)));
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_BLANK_TICK;
        cfg_wdata     = 8'd0;
        s_valid       = 1'b0;
        s_req_type    = REQ_TICK;
        s_button_code = BTN_RUN;
        calm          = 1'b0;
        hold_req      = 1'b0;
        cycle_count   = 0;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // blank at tick 9, drive tens at 10, blank again, drive ones;
        // the tick counter ends at one. Run toggles with no level.
        send_ticks(19);
        send_event(REQ_BUTTON, BTN_RUN);
        send_event(REQ_BUTTON, BTN_RUN);
        send_event(REQ_BUTTON, BTN_RUN);
        drain_results();

        // every tick refreshes from here on
        program_regs(8'd1, 8'd2, SECOND_MATCH_RST);

        // run on with no level: a second at 00 sets the expiry flag,
        // then picking a level starts stage one in the same transaction
        tick_second();
        send_event(REQ_BUTTON, BTN_LEVEL3);
        send_event(REQ_BUTTON, BTN_LEVEL1);
        repeat (2) tick_second();
        send_event(REQ_BUTTON, BTN_RUN);
        repeat (2) tick_second();
        send_event(REQ_BUTTON, BTN_RUN);
        repeat (30) tick_second();

        send_event(REQ_BUTTON, BTN_LEVEL1);
        send_event(REQ_BUTTON, BTN_RUN);
        repeat (16) tick_second();

        send_event(REQ_BUTTON, BTN_LEVEL2);
        send_event(REQ_BUTTON, BTN_RUN);
        repeat (26) tick_second();
        drain_results();

        // a long stretch without any idling
        calm = 1'b1;
        random_events(CALM_ITEMS, 15);
        calm = 1'b0;
        drain_results();

        // random phases over several display settings
        hold_req = 1'b1;
        random_events(PHASE_ITEMS, 15);
        drain_results();

        program_regs(BLANK_TICK_RST, REFRESH_TICK_RST, SECOND_MATCH_RST);
        random_events(PHASE_ITEMS / 2, 15);
        drain_results();
        random_events(PHASE_ITEMS / 2, 15);
        drain_results();

        // blank equal to refresh: blanking wins and the counter wraps
        program_regs(8'd255, 8'd255, 8'd128);
        random_events(PHASE_ITEMS / 2, 10);
        drain_results();

        // out-of-range zero values, and a write to an unused index
        program_regs(8'd0, 8'd0, 8'd0);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= 8'hA5;
        @(negedge aclk);
        cfg_we <= 1'b0;
        random_events(PHASE_ITEMS / 2, 10);
        drain_results();

        // blank above refresh never fires after the first restart
        program_regs(8'd3, 8'd2, 8'd2);
        random_events(PHASE_ITEMS / 2, 20);
        drain_results();

        repeat (4) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
